FILE: design/dediam_pkg.sv
// dediam_pkg: shared constants and item type for the equivalent diameter pipeline
// no dependencies
`timescale 1ns / 1ps

package dediam_pkg;

    localparam int FRAC = 32;
    localparam int G_INT = 12;
    localparam int G_W = G_INT + FRAC;
    localparam int CGH_W = 13;
    localparam int SUM_W = CGH_W + FRAC + 1;
    localparam logic [23:0] COEF_RESET = 24'd516770;
    localparam logic [63:0] C_Q62 = 64'h78F3D1D950AF414C;
    localparam logic [63:0] C_FIX64 = (C_Q62 + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
    localparam logic [FRAC:0] C_FIX = C_FIX64[FRAC:0];
    localparam logic [0:0] ADDR_COEF = 1'b0;

    typedef struct packed {
        logic              valid;
        logic [13:0]       d;
        logic [CGH_W-1:0]  cgh;
        logic [FRAC-1:0]   cgl;
        logic [FRAC-1:0]   y;
        logic              one;
        logic              sat;
    } item_t;

endpackage

FILE: design/dediam_step.sv
// dediam_step: one bit of the search for y in y^3 + C*g*y = 1, four register stages
// depends on dediam_pkg
`timescale 1ns / 1ps

module dediam_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [dediam_pkg::FRAC-1:0]   bit_mask,
    input  dediam_pkg::item_t             item_in,
    output dediam_pkg::item_t             item_out
);

    dediam_pkg::item_t s1_item_reg, s2_item_reg, s3_item_reg, out_reg, out_next;
    logic [dediam_pkg::FRAC-1:0] s1_cand_reg, s2_cand_reg, s3_cand_reg;
    logic [dediam_pkg::FRAC-1:0] s1_y2_reg, s2_y3_reg, s3_y3_reg, s3_cgyl_reg;
    logic [dediam_pkg::CGH_W+dediam_pkg::FRAC-1:0] s3_cgyh_reg;
    logic [dediam_pkg::FRAC-1:0] cand;
    logic [2*dediam_pkg::FRAC-1:0] sq, cube, cgl_prod;
    logic [dediam_pkg::CGH_W+dediam_pkg::FRAC-1:0] cgh_prod;
    logic [dediam_pkg::SUM_W-1:0] lhs;

    assign cand = item_in.y | bit_mask;
    assign sq = (2*dediam_pkg::FRAC)'(cand) * (2*dediam_pkg::FRAC)'(cand);
    assign cube = (2*dediam_pkg::FRAC)'(s1_y2_reg) * (2*dediam_pkg::FRAC)'(s1_cand_reg);
    assign cgl_prod = (2*dediam_pkg::FRAC)'(s2_item_reg.cgl)
                    * (2*dediam_pkg::FRAC)'(s2_cand_reg);
    assign cgh_prod = (dediam_pkg::CGH_W+dediam_pkg::FRAC)'(s2_item_reg.cgh)
                    * (dediam_pkg::CGH_W+dediam_pkg::FRAC)'(s2_cand_reg);
    assign lhs = dediam_pkg::SUM_W'(s3_y3_reg) + dediam_pkg::SUM_W'(s3_cgyl_reg)
               + dediam_pkg::SUM_W'(s3_cgyh_reg);

    always_comb
    begin
        out_next = s3_item_reg;
        if (lhs <= (dediam_pkg::SUM_W'(1) << dediam_pkg::FRAC))
        begin
            out_next.y = s3_cand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_item_reg <= '0;
            s2_item_reg <= '0;
            s3_item_reg <= '0;
            out_reg     <= '0;
        end
        else if (en)
        begin
            s1_item_reg <= item_in;
            s2_item_reg <= s1_item_reg;
            s3_item_reg <= s2_item_reg;
            out_reg     <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cand_reg <= cand;
            s1_y2_reg   <= sq[2*dediam_pkg::FRAC-1:dediam_pkg::FRAC];
            s2_cand_reg <= s1_cand_reg;
            s2_y3_reg   <= cube[2*dediam_pkg::FRAC-1:dediam_pkg::FRAC];
            s3_cand_reg <= s2_cand_reg;
            s3_y3_reg   <= s2_y3_reg;
            s3_cgyl_reg <= cgl_prod[2*dediam_pkg::FRAC-1:dediam_pkg::FRAC];
            s3_cgyh_reg <= cgh_prod;
        end
    end

    assign item_out = out_reg;

endmodule

FILE: design/droplet_equivalent_diameter_unit.sv
// droplet_equivalent_diameter_unit: top level, front end, search chain and output rounding
// depends on dediam_pkg and dediam_step
`timescale 1ns / 1ps

// Takes one item per clock while the output is not stalled and returns one result
// per item, in order. Most of the pipeline is the search for y:
// 32 search steps of four stages each (square, cube, C*g*y, compare), behind five
// front stages that form g and C*g and two output stages that scale and round.
// A stall at the output holds the whole pipeline.

module droplet_equivalent_diameter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [13:0] max_diameter_um,
    input  logic [15:0] velocity_q8_8,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [21:0] equiv_diameter_q14_8,
    output logic        saturated
);

    localparam int FRAC = dediam_pkg::FRAC;
    localparam int G_W = dediam_pkg::G_W;

    logic [23:0] coef_reg;
    logic en;

    logic f1_v_reg, f2_v_reg, f3_v_reg, f4_v_reg;
    logic [13:0] f1_d_reg, f2_d_reg, f3_d_reg, f4_d_reg;
    logic [37:0] f1_kd_reg;
    logic [31:0] f1_vv_reg;
    logic [53:0] f2_plo_reg, f2_phi_reg;
    logic [G_W-1:0] f3_g_reg;
    logic f3_sat_reg, f4_sat_reg;
    logic [69:0] full;
    logic [2*FRAC:0] f4_a_reg;
    logic [FRAC+dediam_pkg::G_INT:0] f4_b_reg;
    logic [FRAC+dediam_pkg::G_INT+1:0] cg;
    dediam_pkg::item_t f5_item_reg;
    dediam_pkg::item_t chain [0:FRAC];

    logic o1_v_reg, o1_sat_reg, o2_v_reg, o2_sat_reg;
    logic [45:0] o1_prod_reg;
    logic [21:0] o2_q_reg;
    logic [45:0] round_sum;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == dediam_pkg::ADDR_COEF) ? {8'd0, coef_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= dediam_pkg::COEF_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == dediam_pkg::ADDR_COEF)
        begin
            coef_reg <= pwdata[23:0];
        end
    end

    assign en = !o2_v_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
            f4_v_reg <= 1'b0;
            o1_v_reg <= 1'b0;
            o2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_v_reg <= in_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
            f4_v_reg <= f3_v_reg;
            o1_v_reg <= chain[FRAC].valid;
            o2_v_reg <= o1_v_reg;
        end
    end

    assign full = {f2_phi_reg, 16'd0} + 70'(f2_plo_reg);
    assign cg = (FRAC+dediam_pkg::G_INT+2)'(f4_b_reg)
              + (FRAC+dediam_pkg::G_INT+2)'(f4_a_reg[2*FRAC:FRAC]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_d_reg   <= max_diameter_um;
            f1_kd_reg  <= 38'(coef_reg) * 38'(max_diameter_um);
            f1_vv_reg  <= 32'(velocity_q8_8) * 32'(velocity_q8_8);
            f2_d_reg   <= f1_d_reg;
            f2_plo_reg <= 54'(f1_kd_reg) * 54'(f1_vv_reg[15:0]);
            f2_phi_reg <= 54'(f1_kd_reg) * 54'(f1_vv_reg[31:16]);
            f3_d_reg   <= f2_d_reg;
            if (full[69:56 + dediam_pkg::G_INT] != '0)
            begin
                f3_g_reg   <= '1;
                f3_sat_reg <= 1'b1;
            end
            else
            begin
                f3_g_reg   <= full[56 + dediam_pkg::G_INT - 1:56 - FRAC];
                f3_sat_reg <= 1'b0;
            end
            f4_d_reg   <= f3_d_reg;
            f4_sat_reg <= f3_sat_reg;
            f4_a_reg   <= (2*FRAC+1)'(dediam_pkg::C_FIX) * (2*FRAC+1)'(f3_g_reg[FRAC-1:0]);
            f4_b_reg   <= (FRAC+dediam_pkg::G_INT+1)'(dediam_pkg::C_FIX)
                        * (FRAC+dediam_pkg::G_INT+1)'(f3_g_reg[G_W-1:FRAC]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f5_item_reg <= '0;
        end
        else if (en)
        begin
            f5_item_reg.valid <= f4_v_reg;
            f5_item_reg.d     <= f4_d_reg;
            f5_item_reg.cgh   <= cg[FRAC+dediam_pkg::CGH_W-1:FRAC];
            f5_item_reg.cgl   <= cg[FRAC-1:0];
            f5_item_reg.y     <= '0;
            f5_item_reg.one   <= (cg == '0);
            f5_item_reg.sat   <= f4_sat_reg;
        end
    end

    assign chain[0] = f5_item_reg;

    for (genvar i = 0; i < FRAC; i++)
    begin : g_step
        dediam_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .bit_mask (FRAC'(1) << (FRAC - 1 - i)),
            .item_in  (chain[i]),
            .item_out (chain[i+1])
        );
    end

    assign round_sum = o1_prod_reg + (46'd1 << (FRAC - 9));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o1_sat_reg  <= chain[FRAC].sat;
            o1_prod_reg <= chain[FRAC].one ? {chain[FRAC].d, {FRAC{1'b0}}}
                                           : 46'(chain[FRAC].d) * 46'(chain[FRAC].y);
            o2_sat_reg  <= o1_sat_reg;
            o2_q_reg    <= round_sum[FRAC-8+21:FRAC-8];
        end
    end

    assign out_valid = o2_v_reg;
    assign equiv_diameter_q14_8 = o2_q_reg;
    assign saturated = o2_sat_reg;

endmodule

FILE: design/dediam_checker.sv
// dediam_checker: port-level checks on the equivalent diameter unit
// bound to droplet_equivalent_diameter_unit
`timescale 1ns / 1ps

module dediam_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [21:0] equiv_diameter_q14_8,
    input logic        saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(equiv_diameter_q14_8)
            && $stable(saturated))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during output stall");

    a_pready: assert property (@(posedge clk) pready)
        else $error("pready low");

endmodule

bind droplet_equivalent_diameter_unit dediam_checker u_dediam_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .pready               (pready),
    .in_ready             (in_ready),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .equiv_diameter_q14_8 (equiv_diameter_q14_8),
    .saturated            (saturated)
);

FILE: sim/testbench.sv
// testbench: self-checking bench for droplet_equivalent_diameter_unit
// depends on dediam_pkg and the unit; bit-exact predictor with a table of directed items
`timescale 1ns / 1ps

module testbench;

    localparam logic [2:0]   REG_COEF = 3'd0;
    localparam logic [23:0]  COEF_MAX = 24'hFFFFFF;
    localparam logic [127:0] ONE_Q = 128'd1 << 32;
    localparam logic [127:0] G_LIMIT = (128'd1 << 44) - 128'd1;
    localparam logic [127:0] CUBIC_C = (128'h78F3D1D950AF414C + (128'd1 << 29)) >> 30;
    localparam int           CYCLE_LIMIT = 400000;
    localparam int           DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [21:0] equiv;
        logic        sat;
    } droplet_res_t;

    typedef struct {
        logic [13:0]  d;
        logic [15:0]  v;
        logic         fixed;
        droplet_res_t want;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [13:0] max_diameter_um;
    logic [15:0] velocity_q8_8;
    logic        out_valid;
    logic        out_ready;
    logic [21:0] equiv_diameter_q14_8;
    logic        saturated;

    droplet_res_t pending_diam[$];
    logic [23:0]  coef;
    int           mismatches;
    int           cycles;
    int           send_idle_pct;
    int           recv_idle_pct;
    logic         hold_go;
    int           hold_cnt;

    droplet_equivalent_diameter_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .max_diameter_um(max_diameter_um),
        .velocity_q8_8(velocity_q8_8),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .equiv_diameter_q14_8(equiv_diameter_q14_8),
        .saturated(saturated)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic droplet_res_t equiv_diameter(logic [23:0] k, logic [13:0] d,
                                                    logic [15:0] v);
        logic [127:0] g;
        logic [127:0] cg;
        logic [127:0] y;
        logic [127:0] cand;
        logic [127:0] y2;
        logic [127:0] y3;
        logic [127:0] cgy;
        droplet_res_t r;
        g = (128'(k) * 128'(d) * 128'(v) * 128'(v)) >> 24;
        r.sat = g > G_LIMIT;
        if (r.sat)
        begin
            g = G_LIMIT;
        end
        cg = (CUBIC_C * g) >> 32;
        y = 128'd0;
        for (int b = 32; b >= 0; b--)
        begin
            cand = y | (128'd1 << b);
            y2 = (cand * cand) >> 32;
            y3 = (y2 * cand) >> 32;
            cgy = ((cg * cand) >> 32) & 128'hFFFF_FFFF_FFFF_FFFF;
            if (cand <= ONE_Q && ((y3 + cgy) & 128'hFFFF_FFFF_FFFF_FFFF) <= ONE_Q)
            begin
                y = cand;
            end
        end
        r.equiv = 22'((128'(d) * y + (128'd1 << 23)) >> 24);
        return r;
    endfunction

    // output side: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt <= 0;
        end
        else if (hold_go && hold_cnt < 400)
        begin
            out_ready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        droplet_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_diam.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected item: equiv %0d sat %0d",
                             equiv_diameter_q14_8, saturated);
                end
            end
            else
            begin
                want = pending_diam.pop_front();
                if (want.equiv !== equiv_diameter_q14_8 || want.sat !== saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected equiv %0d sat %0d, got equiv %0d sat %0d",
                                 want.equiv, want.sat, equiv_diameter_q14_8, saturated);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_droplet(logic [13:0] d, logic [15:0] v, logic fixed,
                                droplet_res_t want);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        max_diameter_um <= d;
        velocity_q8_8 <= v;
        do @(posedge clk); while (!in_ready);
        pending_diam.push_back(fixed ? want : equiv_diameter(coef, d, v));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_diam.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_coef(logic [23:0] k);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= REG_COEF;
        pwdata <= {8'hA5, k};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        coef = k;
    endtask

    task automatic random_droplets(int count);
        logic [15:0] v;
        for (int i = 0; i < count; i++)
        begin
            v = 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
            send_droplet(14'($urandom_range(0, 16383) >> $urandom_range(0, 4)), v,
                         1'b0, '0);
        end
    endtask

    initial
    begin
        table_row_t rows [0:15];
        rows = '{
            '{14'd16383, 16'd0,     1'b1, '{22'd4194048, 1'b0}},
            '{14'd0,     16'd65535, 1'b1, '{22'd0,       1'b0}},
            '{14'd0,     16'd0,     1'b1, '{22'd0,       1'b0}},
            '{14'd1,     16'd0,     1'b1, '{22'd256,     1'b0}},
            '{14'd16383, 16'd65535, 1'b0, '{22'd0,       1'b0}},
            '{14'd1,     16'd1,     1'b0, '{22'd0,       1'b0}},
            '{14'd1,     16'd65535, 1'b0, '{22'd0,       1'b0}},
            '{14'd16383, 16'd1,     1'b0, '{22'd0,       1'b0}},
            '{14'd2000,  16'd2304,  1'b0, '{22'd0,       1'b0}},
            '{14'd500,   16'd1280,  1'b0, '{22'd0,       1'b0}},
            '{14'd8191,  16'd32768, 1'b0, '{22'd0,       1'b0}},
            '{14'd10000, 16'd16384, 1'b0, '{22'd0,       1'b0}},
            '{14'd12345, 16'd4000,  1'b0, '{22'd0,       1'b0}},
            '{14'd5461,  16'd43690, 1'b0, '{22'd0,       1'b0}},
            '{14'd10922, 16'd21845, 1'b0, '{22'd0,       1'b0}},
            '{14'd3000,  16'd60000, 1'b0, '{22'd0,       1'b0}}
        };
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        max_diameter_um = '0;
        velocity_q8_8 = '0;
        hold_go = 1'b0;
        mismatches = 0;
        cycles = 0;
        coef = dediam_pkg::COEF_RESET;
        send_idle_pct = 9;
        recv_idle_pct = 67;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            send_droplet(rows[i].d, rows[i].v, rows[i].fixed, rows[i].want);
        end
        random_droplets(330);
        drain();

        write_coef(24'd0);
        random_droplets(200);
        drain();

        send_idle_pct = 67;
        recv_idle_pct = 9;
        write_coef(COEF_MAX);
        send_droplet(14'd16383, 16'd65535, 1'b0, '0);
        random_droplets(250);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_coef(24'($urandom_range(0, 16777215)));
        hold_go <= 1'b1;
        random_droplets(350);
        drain();

        write_coef(24'd1);
        random_droplets(120);
        write_coef_after_drain : begin
            drain();
            write_coef(dediam_pkg::COEF_RESET);
        end
        random_droplets(150);
        drain();

        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
